### hdl/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg: shared types for the double-ended queue with search
// Request and status codes, and the states of the block's sequencer.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int unsigned ItemBits = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CONTAINS   = 3'd4,
    REQ_REMOVE     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ_F,
    S_READ_B,
    S_FIN
  } state_e;

endpackage

### hdl/deque_bag_store.sv
// ----------------------------------------------------------------------------
// deque_bag_store: bounded double-ended queue with search and removal
// A circular buffer in RAM, walked one entry a cycle by a small sequencer
// for searches and for closing the gap left by a removal.
// ----------------------------------------------------------------------------
//  channel   ports                                  transfer when
//  request   start_i, req_type_i, item_value_i      start_i high and busy_o low
//  result    done_o, status_o, found_o,             done_o high (one cycle)
//            entry_count_o, is_empty_o,
//            front_value_o, back_value_o
//
// Pushes, pops and unused codes pass through the read states S_READ_F, S_READ_B
// and S_FIN, which read front and back back from the RAM; S_READ_F alone ends
// the request when the store is left empty. Contains adds a scan through the RAM
// read port; remove adds a shift of the entries behind the match at position p.
// A new request is taken in the cycle that shows done_o.
// Reset leaves the store empty; the RAM contents are not cleared.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module deque_bag_store #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 req_type_i,
  input  logic signed [31:0]         item_value_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic                       found_o,
  output logic [$clog2(DEPTH+1)-1:0] entry_count_o,
  output logic                       is_empty_o,
  output logic signed [31:0]         front_value_o,
  output logic signed [31:0]         back_value_o
);
  import dbs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned XW = (VALUE_BITS > ItemBits) ? VALUE_BITS : ItemBits;

  // Position within the queue to physical slot, head + pos wrapped once.
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                            input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e                 state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   done_q, done_d;
  logic                   cmp_vld_q, cmp_vld_d;
  req_e                   req_q, req_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          scan_q, scan_d;
  status_e                status_q, status_d;
  logic                   found_q, found_d;
  logic [ItemBits-1:0]    front_q, front_d;
  logic [ItemBits-1:0]    back_q, back_d;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_BITS-1:0]  wr_data;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_BITS-1:0]  rd_data;
  logic [XW-1:0]          in_ext;
  logic [XW-1:0]          rd_ext;
  logic [AW-1:0]          head_inc, head_dec;
  logic                   is_full;

  // Values are kept sign-extended to VALUE_BITS and reported zero-extended.
  assign in_ext   = XW'(item_value_i);
  assign rd_ext   = XW'(rd_data);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign is_full  = (count_q == CW'(DEPTH));

  dbs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      done_q    <= done_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    scan_q   <= scan_d;
    status_q <= status_d;
    found_q  <= found_d;
    front_q  <= front_d;
    back_q   <= back_d;
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    done_d    = 1'b0;
    cmp_vld_d = 1'b0;
    req_d     = req_q;
    val_d     = val_q;
    pos_d     = pos_q;
    scan_d    = scan_q;
    status_d  = status_q;
    found_d   = found_q;
    front_d   = front_q;
    back_d    = back_q;
    wr_en     = 1'b0;
    wr_addr   = slot_at(head_q, count_q);
    wr_data   = in_ext[VALUE_BITS-1:0];
    rd_addr   = slot_at(head_q, scan_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_e'(req_type_i);
          val_d    = in_ext[VALUE_BITS-1:0];
          status_d = STAT_OK;
          found_d  = 1'b0;
          scan_d   = '0;
          pos_d    = '0;
          state_d  = S_READ_F;
          unique case (req_type_i) inside
            REQ_PUSH_FRONT: begin
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                head_d  = head_dec;
                wr_en   = 1'b1;
                wr_addr = head_dec;
                count_d = count_q + CW'(1);
              end
            end
            REQ_PUSH_BACK: begin
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            REQ_POP_FRONT: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - CW'(1);
              end
            end
            REQ_POP_BACK: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            REQ_CONTAINS, REQ_REMOVE: begin
              if (count_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // Each cycle compares the entry read in the previous cycle and issues
      // the read of the next one.
      S_SCAN: begin
        if (cmp_vld_q && (rd_data == val_q)) begin
          found_d = 1'b1;
          if (req_q == REQ_REMOVE) begin
            if (CW'(pos_q) == count_q - CW'(1)) begin
              count_d = count_q - CW'(1);
              state_d = S_READ_F;
            end else begin
              rd_addr = slot_at(head_q, CW'(pos_q) + CW'(1));
              state_d = S_SHIFT;
            end
          end else begin
            state_d = S_READ_F;
          end
        end else if (scan_q == count_q) begin
          state_d = S_READ_F;
        end else begin
          cmp_vld_d = 1'b1;
          pos_d     = scan_q[AW-1:0];
          scan_d    = scan_q + CW'(1);
        end
      end

      // The entry behind pos_q is in the read register; move it down one
      // place while the one after it is read.
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = slot_at(head_q, CW'(pos_q));
        wr_data = rd_data;
        if ((SW'(pos_q) + SW'(2)) == SW'(count_q)) begin
          count_d = count_q - CW'(1);
          state_d = S_READ_F;
        end else begin
          rd_addr = slot_at(head_q, CW'(pos_q) + CW'(2));
          pos_d   = pos_q + AW'(1);
        end
      end

      S_READ_F: begin
        if (count_q == '0) begin
          front_d = '0;
          back_d  = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_addr = head_q;
          state_d = S_READ_B;
        end
      end

      S_READ_B: begin
        rd_addr = slot_at(head_q, count_q - CW'(1));
        front_d = rd_ext[ItemBits-1:0];
        state_d = S_FIN;
      end

      S_FIN: begin
        back_d  = rd_ext[ItemBits-1:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = (count_q == '0);
  assign front_value_o = front_q;
  assign back_value_o  = back_q;

endmodule

### hdl/dbs_ram.sv
// ----------------------------------------------------------------------------
// dbs_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/dbs_checker.sv
// ----------------------------------------------------------------------------
// dbs_checker: port-level checks for deque_bag_store
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module dbs_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic                       found_o,
  input logic [$clog2(DEPTH+1)-1:0] entry_count_o,
  input logic                       is_empty_o,
  input logic signed [31:0]         front_value_o,
  input logic signed [31:0]         back_value_o
);
  import dbs_pkg::*;

  // An accepted request always leaves the block busy in the cycle after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after an accepted request");

  // A result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (entry_count_o == '0)) && (entry_count_o <= DEPTH))
    else $error("entry count and empty flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_empty_o |-> (front_value_o == '0) && (back_value_o == '0))
    else $error("empty store reports non-zero front or back value");

  // Only searches can match, and they never report a full or empty status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> (status_o == STAT_OK) && !is_empty_o || found_o && done_o
      && (status_o == STAT_OK))
    else $error("match reported together with an error status");

endmodule

bind deque_bag_store dbs_checker #(.DEPTH(DEPTH)) u_dbs_checker (.*);

### bench/deque_bag_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_bag_store_tb: self-checking bench for the double-ended queue with search
// Requests are sent through the start/busy handshake and every result strobe
// is compared field by field with a behavioural copy of the store, kept in
// step with each accepted request. Directed cases on an empty store, extreme
// values and duplicates are followed by random traffic that moves the fill
// level between empty and full, under several sender idling phases.
// ----------------------------------------------------------------------------
module deque_bag_store_tb;
  import dbs_pkg::*;

  localparam int DEPTH = 16;
  localparam int ValueBits = ItemBits;
  // Request codes that the block treats as no operation.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  // The slowest request (remove from a full store) finishes well inside this.
  localparam int DrainCycles = 64;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [4:0]           count;
    logic                 empty;
    logic [ValueBits-1:0] front;
    logic [ValueBits-1:0] back;
  } outcome_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [2:0]            req_type_i;
  logic signed [31:0]    item_value_i;
  logic                  done_o;
  logic [1:0]            status_o;
  logic                  found_o;
  logic [4:0]            entry_count_o;
  logic                  is_empty_o;
  logic signed [31:0]    front_value_o;
  logic signed [31:0]    back_value_o;

  // Behavioural copy of the store.
  logic [ValueBits-1:0]  store_slots [DEPTH];
  int                    store_head;
  int                    store_count;

  outcome_t              outcome_q [$];
  int                    mismatch_count;
  int                    idle_pct;

  deque_bag_store #(
    .DEPTH     (DEPTH),
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(64'd4_000_000);
    $display("deque_bag_store: mismatch");
    $finish;
  end

  function automatic int slot_pos(input int offset);
    return (store_head + offset) % DEPTH;
  endfunction

  // Applies one request to the copy of the store and returns what it reports.
  function automatic outcome_t deque_update(input logic [2:0] code,
                                            input logic [ValueBits-1:0] value);
    outcome_t res;
    int       p;
    int       i;
    bit       hit;
    res = '0;
    res.status = STAT_OK;
    hit = 1'b0;
    p = 0;
    case (code)
      REQ_PUSH_FRONT: begin
        if (store_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          store_head = (store_head + DEPTH - 1) % DEPTH;
          store_slots[store_head] = value;
          store_count++;
        end
      end
      REQ_PUSH_BACK: begin
        if (store_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          store_slots[slot_pos(store_count)] = value;
          store_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (store_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          store_head = (store_head + 1) % DEPTH;
          store_count--;
        end
      end
      REQ_POP_BACK: begin
        if (store_count == 0) res.status = STAT_EMPTY;
        else store_count--;
      end
      REQ_CONTAINS, REQ_REMOVE: begin
        for (p = 0; p < store_count; p++) begin
          if (store_slots[slot_pos(p)] == value) begin
            hit = 1'b1;
            break;
          end
        end
        // Removal closes the gap, so the entries behind the match move up.
        if (hit && code == REQ_REMOVE) begin
          for (i = p; i + 1 < store_count; i++)
            store_slots[slot_pos(i)] = store_slots[slot_pos(i + 1)];
          store_count--;
        end
      end
      default: ;
    endcase
    res.found = hit;
    res.count = 5'(store_count);
    res.empty = (store_count == 0);
    if (store_count != 0) begin
      res.front = store_slots[slot_pos(0)];
      res.back  = store_slots[slot_pos(store_count - 1)];
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s differs, expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    outcome_t exp_r;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        flag_mismatch("unrequested result", '0, '0);
      end else begin
        exp_r = outcome_q.pop_front();
        if (status_o !== exp_r.status) flag_mismatch("status", exp_r.status, status_o);
        if (found_o !== exp_r.found) flag_mismatch("found", exp_r.found, found_o);
        if (entry_count_o !== exp_r.count)
          flag_mismatch("entry_count", exp_r.count, entry_count_o);
        if (is_empty_o !== exp_r.empty) flag_mismatch("is_empty", exp_r.empty, is_empty_o);
        if (front_value_o !== exp_r.front)
          flag_mismatch("front_value", exp_r.front, front_value_o);
        if (back_value_o !== exp_r.back)
          flag_mismatch("back_value", exp_r.back, back_value_o);
      end
    end
  end

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 60 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // Offers one request and returns once the transfer has taken place.
  task automatic send_req(input logic [2:0] code, input logic [ValueBits-1:0] value);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= code;
    item_value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    outcome_q.push_back(deque_update(code, value));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueBits-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (store_count > 0 && r < 40)
      return store_slots[slot_pos($urandom_range(store_count - 1))];
    // A small pool of values gives plenty of duplicates.
    if (r < 70) return 32'($urandom_range(7)) - 32'd3;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_code(input int target);
    int r;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
    if (r < 10) return 3'($urandom_range(7));
    if (r < 33) return REQ_CONTAINS;
    if (r < 48) return REQ_REMOVE;
    if (store_count < target)
      return $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    if (store_count > target)
      return $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
    return 3'($urandom_range(3));
  endfunction

  task automatic test_empty_store();
    send_req(REQ_POP_FRONT, 32'h1234_5678);
    send_req(REQ_POP_BACK, 32'hFFFF_FFFF);
    send_req(REQ_CONTAINS, 32'h0);
    send_req(REQ_REMOVE, 32'h0);
    send_req(REQ_UNUSED_LO, 32'h8000_0000);
    send_req(REQ_UNUSED_HI, 32'h7FFF_FFFF);
  endtask

  task automatic test_extreme_values();
    send_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_BACK, 32'h8000_0000);
    send_req(REQ_PUSH_FRONT, 32'h0);
    send_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_req(REQ_CONTAINS, 32'h8000_0000);
    send_req(REQ_CONTAINS, 32'h7FFF_FFFF);
    send_req(REQ_CONTAINS, 32'h0000_0001);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
  endtask

  task automatic test_duplicates();
    send_req(REQ_REMOVE, 32'h7FFF_FFFF);
    send_req(REQ_REMOVE, 32'h8000_0000);
    send_req(REQ_PUSH_BACK, 32'd5);
    send_req(REQ_PUSH_BACK, 32'd9);
    send_req(REQ_PUSH_BACK, 32'd5);
    // Only the copy nearest the front goes.
    send_req(REQ_REMOVE, 32'd5);
    send_req(REQ_CONTAINS, 32'd5);
    send_req(REQ_REMOVE, 32'd5);
    send_req(REQ_REMOVE, 32'd9);
  endtask

  task automatic test_full_store();
    wait_for_results();
    while (store_count < DEPTH)
      send_req($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
    send_req(REQ_PUSH_FRONT, $urandom);
    send_req(REQ_PUSH_BACK, $urandom);
    send_req(REQ_CONTAINS, store_slots[slot_pos(DEPTH - 1)]);
    send_req(REQ_REMOVE, store_slots[slot_pos(DEPTH / 2)]);
    send_req(REQ_PUSH_BACK, $urandom);
    send_req(REQ_REMOVE, store_slots[slot_pos(0)]);
    while (store_count > 0)
      send_req($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
    send_req(REQ_POP_BACK, $urandom);
  endtask

  task automatic test_random_ops(input int n_items);
    int target;
    int k;
    target = $urandom_range(DEPTH);
    for (k = 0; k < n_items; k++) begin
      // The fill level drifts towards a target that changes now and then,
      // with the extremes picked often enough to see full and empty stores.
      if ($urandom_range(29) == 0) begin
        if ($urandom_range(2) == 0) target = $urandom_range(1) ? DEPTH : 0;
        else target = $urandom_range(DEPTH);
      end
      send_req(pick_code(target), pick_value());
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_type_i     = REQ_PUSH_FRONT;
    item_value_i   = '0;
    mismatch_count = 0;
    idle_pct       = 0;
    store_head     = 0;
    store_count    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_extreme_values();
    test_duplicates();
    test_random_ops(450);
    idle_pct = 81;
    test_full_store();
    test_random_ops(450);
    idle_pct = 20;
    test_random_ops(450);
    idle_pct = 0;
    test_full_store();
    test_random_ops(450);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("deque_bag_store: match");
    end else begin
      $display("deque_bag_store: mismatch");
    end
    $finish;
  end

endmodule
